// ===== sv/ceas_pkg.sv =====
package ceas_pkg;

  // addressing mode codes
  localparam logic [3:0] MODE_IMP  = 4'd0;
  localparam logic [3:0] MODE_ACC  = 4'd1;
  localparam logic [3:0] MODE_IMM  = 4'd2;
  localparam logic [3:0] MODE_ZP   = 4'd3;
  localparam logic [3:0] MODE_ABS  = 4'd4;
  localparam logic [3:0] MODE_REL  = 4'd5;
  localparam logic [3:0] MODE_IND  = 4'd6;
  localparam logic [3:0] MODE_ZPX  = 4'd7;
  localparam logic [3:0] MODE_ZPY  = 4'd8;
  localparam logic [3:0] MODE_ABSY = 4'd9;
  localparam logic [3:0] MODE_ABSX = 4'd10;
  localparam logic [3:0] MODE_INDX = 4'd11;
  localparam logic [3:0] MODE_INDY = 4'd12;

  // request and result kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // step counts within a mode
  localparam logic [2:0] STEP_0 = 3'd0;
  localparam logic [2:0] STEP_1 = 3'd1;
  localparam logic [2:0] STEP_2 = 3'd2;

  localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;
  localparam logic [15:0] ZP_MASK        = 16'h00FF;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  mode;
    logic [15:0] operand_pc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  read_byte;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] read_address;
    logic [15:0] effective_address;
    logic [15:0] next_pc;
    logic        cross_page;
  } out_word_t;

  // sequencer state carried between words
  typedef struct packed {
    logic [3:0]  mode;
    logic        busy;
    logic [2:0]  step;
    logic [15:0] pc;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [7:0]  lo;
    logic [15:0] ptr;
    logic        pcf;
  } state_t;

endpackage

// ===== sv/ceas_if.sv =====
interface ceas_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  mode;
  logic [15:0] operand_pc;
  logic [7:0]  index_x;
  logic [7:0]  index_y;
  logic [7:0]  read_byte;

  modport source (output valid, req_type, mode, operand_pc, index_x, index_y, read_byte,
                  input ready);
  modport sink   (input valid, req_type, mode, operand_pc, index_x, index_y, read_byte,
                  output ready);
endinterface

interface ceas_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] read_address;
  logic [15:0] effective_address;
  logic [15:0] next_pc;
  logic        cross_page;

  modport source (output valid, result_kind, read_address, effective_address, next_pc,
                  cross_page, input ready);
  modport sink   (input valid, result_kind, read_address, effective_address, next_pc,
                  cross_page, output ready);
endinterface

// ===== sv/ceas_step.sv =====
module ceas_step (
  input  ceas_pkg::state_t    st,
  input  ceas_pkg::in_word_t  word,
  output ceas_pkg::state_t    st_nxt,
  output logic                emit,
  output ceas_pkg::out_word_t res
);

  logic [7:0]  b;
  logic [15:0] pc_inc;
  logic [15:0] rel_off;
  logic [15:0] full_addr;
  logic [7:0]  idx;
  logic [15:0] idx_sum;
  logic        idx_cross;
  logic [7:0]  zpx_addr;
  logic [7:0]  zpy_addr;
  logic [7:0]  ptr_lo_inc;
  logic [7:0]  indx_ptr;

  assign b          = word.read_byte;
  assign pc_inc     = st.pc + 16'd1;
  assign rel_off    = {{8{b[7]}}, b};
  assign full_addr  = {b, st.lo};
  assign idx        = (st.mode == ceas_pkg::MODE_ABSX) ? st.sx : st.sy;
  assign idx_sum    = full_addr + {8'h00, idx};
  assign idx_cross  = (full_addr & ceas_pkg::HIGH_BYTE_MASK) !=
                      (idx_sum & ceas_pkg::HIGH_BYTE_MASK);
  assign zpx_addr   = b + st.sx;
  assign zpy_addr   = b + st.sy;
  assign ptr_lo_inc = st.ptr[7:0] + 8'd1;
  assign indx_ptr   = b + st.sx;

  always_comb begin
    st_nxt                = st;
    emit                  = 1'b0;
    res.result_kind       = ceas_pkg::KIND_READ;
    res.read_address      = 16'h0000;
    res.effective_address = 16'h0000;
    res.next_pc           = 16'h0000;
    res.cross_page        = st.pcf;

    if (word.req_type == ceas_pkg::REQ_START) begin
      st_nxt.mode = word.mode;
      st_nxt.pc   = word.operand_pc;
      st_nxt.sx   = word.index_x;
      st_nxt.sy   = word.index_y;
      st_nxt.step = ceas_pkg::STEP_0;
      st_nxt.busy = 1'b0;
      emit        = 1'b1;
      if (word.mode == ceas_pkg::MODE_IMM) begin
        res.result_kind       = ceas_pkg::KIND_DONE;
        res.effective_address = word.operand_pc;
        res.next_pc           = word.operand_pc + 16'd1;
      end else if (!(word.mode inside {[ceas_pkg::MODE_IMM : ceas_pkg::MODE_INDY]})) begin
        res.result_kind = ceas_pkg::KIND_DONE;
        res.next_pc     = word.operand_pc;
      end else begin
        // fetch first operand byte
        st_nxt.busy      = 1'b1;
        st_nxt.pc        = word.operand_pc + 16'd1;
        res.read_address = word.operand_pc;
      end
    end else if (st.busy) begin
      emit        = 1'b1;
      st_nxt.step = st.step + 3'd1;
      // completion defaults; read paths override below
      res.result_kind = ceas_pkg::KIND_DONE;
      res.next_pc     = st.pc;
      case (st.mode)
        ceas_pkg::MODE_ZP: begin
          res.effective_address = {8'h00, b};
        end
        ceas_pkg::MODE_REL: begin
          res.effective_address = st.pc + rel_off;
        end
        ceas_pkg::MODE_ZPX: begin
          res.effective_address = {8'h00, zpx_addr};
        end
        ceas_pkg::MODE_ZPY: begin
          res.effective_address = {8'h00, zpy_addr};
        end
        ceas_pkg::MODE_ABS, ceas_pkg::MODE_ABSX, ceas_pkg::MODE_ABSY: begin
          if (st.step == ceas_pkg::STEP_0) begin
            st_nxt.lo        = b;
            st_nxt.pc        = pc_inc;
            res.result_kind  = ceas_pkg::KIND_READ;
            res.read_address = st.pc;
            res.next_pc      = 16'h0000;
          end else if (st.mode == ceas_pkg::MODE_ABS) begin
            res.effective_address = full_addr;
          end else begin
            st_nxt.pcf            = idx_cross;
            res.cross_page        = idx_cross;
            res.effective_address = idx_sum;
          end
        end
        ceas_pkg::MODE_IND: begin
          if (st.step == ceas_pkg::STEP_0) begin
            st_nxt.lo        = b;
            st_nxt.pc        = pc_inc;
            res.result_kind  = ceas_pkg::KIND_READ;
            res.read_address = st.pc;
            res.next_pc      = 16'h0000;
          end else if (st.step == ceas_pkg::STEP_1) begin
            st_nxt.ptr       = full_addr;
            res.result_kind  = ceas_pkg::KIND_READ;
            res.read_address = full_addr;
            res.next_pc      = 16'h0000;
          end else if (st.step == ceas_pkg::STEP_2) begin
            // high byte pointer stays inside the same page
            st_nxt.lo        = b;
            res.result_kind  = ceas_pkg::KIND_READ;
            res.read_address = {st.ptr[15:8], ptr_lo_inc};
            res.next_pc      = 16'h0000;
          end else begin
            res.effective_address = full_addr;
          end
        end
        ceas_pkg::MODE_INDX, ceas_pkg::MODE_INDY: begin
          if (st.step == ceas_pkg::STEP_0) begin
            if (st.mode == ceas_pkg::MODE_INDX) begin
              st_nxt.ptr       = {8'h00, indx_ptr};
              res.read_address = {8'h00, indx_ptr};
            end else begin
              st_nxt.ptr       = {8'h00, b};
              res.read_address = {8'h00, b};
            end
            res.result_kind = ceas_pkg::KIND_READ;
            res.next_pc     = 16'h0000;
          end else if (st.step == ceas_pkg::STEP_1) begin
            st_nxt.lo        = b;
            res.result_kind  = ceas_pkg::KIND_READ;
            res.read_address = {8'h00, ptr_lo_inc} & ceas_pkg::ZP_MASK;
            res.next_pc      = 16'h0000;
          end else if (st.mode == ceas_pkg::MODE_INDX) begin
            res.effective_address = full_addr;
          end else begin
            st_nxt.pcf            = idx_cross;
            res.cross_page        = idx_cross;
            res.effective_address = idx_sum;
          end
        end
        default: begin
          res.effective_address = 16'h0000;
        end
      endcase
      if (res.result_kind == ceas_pkg::KIND_DONE) begin
        st_nxt.busy = 1'b0;
        st_nxt.step = ceas_pkg::STEP_0;
      end
    end
  end

endmodule

// ===== sv/cpu_effective_address_sequencer.sv =====
// effective-address sequencer for the classic 8-bit cpu addressing modes
// in_ch: a start word (req_type 0) brings mode, operand pc, x and y; each
// later word (req_type 1) returns the byte for the last read request
// out_ch: every start word and every byte word taken while a calculation is
// running yields one result word: either a read request (result_kind 0) or
// the finished effective address with next pc and page-cross flag
// a byte word that arrives with no calculation running yields nothing
// a word taken from in_ch is held in the input register and evaluated
// from there; its result is loaded into the output register once that
// register is free or being emptied, and then appears on out_ch
// throughput: one word per cycle while out_ch is taken; both registers
// hold one word each, so in_ch accepts one more while a result waits
// stall: if out_ch is not taken the result holds, the input register fills
// and in_ch.ready drops until the receiver takes the pending result
// reset (rst_n low, synchronous): both registers empty, sequencer state and
// page-cross flag cleared to zero
module cpu_effective_address_sequencer (
  input logic               clk,
  input logic               rst_n,
  ceas_in_if.sink           in_ch,
  ceas_out_if.source        out_ch
);

  // input register
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  ceas_pkg::in_word_t  s1_word_r;
  ceas_pkg::in_word_t  in_word;

  // sequencer state
  ceas_pkg::state_t    st_r;
  ceas_pkg::state_t    st_nxt;

  // output register
  logic                out_valid_r;
  logic                out_valid_nxt;
  ceas_pkg::out_word_t out_word_r;

  // evaluation of the word in the input register
  ceas_pkg::state_t    step_st;
  logic                step_emit;
  ceas_pkg::out_word_t step_res;

  logic                s1_go;
  logic                in_take;

  assign in_word.req_type   = in_ch.req_type;
  assign in_word.mode       = in_ch.mode;
  assign in_word.operand_pc = in_ch.operand_pc;
  assign in_word.index_x    = in_ch.index_x;
  assign in_word.index_y    = in_ch.index_y;
  assign in_word.read_byte  = in_ch.read_byte;

  ceas_step u_step (
    .st     (st_r),
    .word   (s1_word_r),
    .st_nxt (step_st),
    .emit   (step_emit),
    .res    (step_res)
  );

  // the held word moves on once the output slot is free or being emptied
  assign s1_go   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = step_emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign st_nxt = s1_go ? step_st : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
    if (s1_go && step_emit) begin
      out_word_r <= step_res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.result_kind       = out_word_r.result_kind;
  assign out_ch.read_address      = out_word_r.read_address;
  assign out_ch.effective_address = out_word_r.effective_address;
  assign out_ch.next_pc           = out_word_r.next_pc;
  assign out_ch.cross_page        = out_word_r.cross_page;

endmodule
